[hw/rtl/ptw_pkg.sv]
`default_nettype none

package ptw_pkg;

  localparam int DEF_FRAME_BITS = 40;

  // input item kinds
  localparam logic [2:0] KIND_TRANSLATE  = 3'd0;
  localparam logic [2:0] KIND_MAP        = 3'd1;
  localparam logic [2:0] KIND_UNMAP      = 3'd2;
  localparam logic [2:0] KIND_READ_RESP  = 3'd3;
  localparam logic [2:0] KIND_ALLOC_RESP = 3'd4;

  // walk operations
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;

  // result kinds
  localparam logic [2:0] RES_READ     = 3'd0;
  localparam logic [2:0] RES_WRITE    = 3'd1;
  localparam logic [2:0] RES_REQ_PAGE = 3'd2;
  localparam logic [2:0] RES_CLEAR    = 3'd3;
  localparam logic [2:0] RES_INVAL    = 3'd4;
  localparam logic [2:0] RES_DONE     = 3'd5;

  // done status
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_NO_MEM      = 2'd2;

  // saved flag bits
  localparam int FLAG_W  = 0;
  localparam int FLAG_U  = 1;
  localparam int FLAG_NX = 2;

  localparam logic [1:0] LEAF_LEVEL = 2'd3;

  // entry bits
  localparam logic [63:0] ENT_P  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] ENT_W  = 64'h0000_0000_0000_0002;
  localparam logic [63:0] ENT_U  = 64'h0000_0000_0000_0004;
  localparam logic [63:0] ENT_NX = 64'h8000_0000_0000_0000;

  localparam logic [8:0]  IDX_MASK = 9'h1FF;
  localparam logic [11:0] OFS_MASK = 12'hFFF;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [39:0] root_frame;
    logic [47:0] virt_address;
    logic [39:0] phys_frame;
    logic        set_writable;
    logic        set_user;
    logic        set_no_exec;
    logic [63:0] read_data;
    logic [39:0] alloc_frame;
  } req_t;

  typedef struct packed {
    logic [2:0]  res_kind;
    logic [51:0] mem_address;
    logic [63:0] write_data;
    logic [1:0]  status;
    logic [51:0] phys_result;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]              count;
    res_t [MAX_RES-1:0]      item;
  } batch_t;

  function automatic res_t make_res(logic [2:0] kind, logic [51:0] addr, logic [63:0] data,
                                    logic [1:0] st, logic [51:0] phys, logic lst);
    res_t r;
    r.res_kind    = kind;
    r.mem_address = addr;
    r.write_data  = data;
    r.status      = st;
    r.phys_result = phys;
    r.last        = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ptw_walk.sv]
`default_nettype none

module ptw_walk import ptw_pkg::*; #(
  parameter int FRAME_BITS = DEF_FRAME_BITS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  req_t   request,
  output batch_t batch
);

  localparam logic [63:0] FRAME_MASK64 = 64'((65'd1 << FRAME_BITS) - 65'd1);
  localparam logic [63:0] ENT_FRAME    = FRAME_MASK64 << 12;
  localparam logic [63:0] KEEP_MASK    = ~(ENT_P | ENT_W | ENT_U | ENT_NX | ENT_FRAME);

  logic                  active, active_next;
  logic                  awaiting, awaiting_next;
  logic [1:0]            operation, operation_next;
  logic [1:0]            level, level_next;
  logic [FRAME_BITS-1:0] table_frame, table_frame_next;
  logic [47:0]           saved_virt, saved_virt_next;
  logic [FRAME_BITS-1:0] saved_phys_frame, saved_phys_frame_next;
  logic [2:0]            saved_flags, saved_flags_next;
  logic [63:0]           old_entry, old_entry_next;

  logic [FRAME_BITS-1:0] ent_frame;
  logic [FRAME_BITS-1:0] new_alloc;
  logic [1:0]            level_inc;
  logic                  user;
  logic [63:0]           rdata;

  function automatic logic [51:0] entry_addr(logic [FRAME_BITS-1:0] frame, logic [47:0] va,
                                             logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39] & IDX_MASK;
      2'd1:    idx = va[38:30] & IDX_MASK;
      2'd2:    idx = va[29:21] & IDX_MASK;
      default: idx = va[20:12] & IDX_MASK;
    endcase
    return {40'(frame), idx, 3'b000};
  endfunction

  function automatic logic [63:0] compose(logic [63:0] old, logic p, logic w, logic u,
                                          logic nx, logic [FRAME_BITS-1:0] frame);
    logic [63:0] e;
    e = old & KEEP_MASK;
    if (p) e = e | ENT_P;
    if (w) e = e | ENT_W;
    if (u) e = e | ENT_U;
    if (nx) e = e | ENT_NX;
    return e | (64'(frame) << 12);
  endfunction

  assign rdata     = request.read_data;
  assign ent_frame = rdata[12 +: FRAME_BITS];
  assign new_alloc = request.alloc_frame[FRAME_BITS-1:0];
  assign level_inc = level + 2'd1;
  assign user      = saved_flags[FLAG_U];

  always_comb begin
    active_next           = active;
    awaiting_next         = awaiting;
    operation_next        = operation;
    level_next            = level;
    table_frame_next      = table_frame;
    saved_virt_next       = saved_virt;
    saved_phys_frame_next = saved_phys_frame;
    saved_flags_next      = saved_flags;
    old_entry_next        = old_entry;
    batch                 = '0;
    if (accept) begin
      case (request.kind)
        KIND_TRANSLATE, KIND_MAP, KIND_UNMAP: begin
          if (!active) begin
            active_next           = 1'b1;
            awaiting_next         = 1'b0;
            operation_next        = request.kind[1:0];
            level_next            = 2'd0;
            table_frame_next      = request.root_frame[FRAME_BITS-1:0];
            saved_virt_next       = request.virt_address;
            saved_phys_frame_next = request.phys_frame[FRAME_BITS-1:0];
            saved_flags_next      = {request.set_no_exec, request.set_user, request.set_writable};
            old_entry_next        = '0;
            batch.count           = 2'd1;
            batch.item[0] = make_res(RES_READ,
                                     entry_addr(request.root_frame[FRAME_BITS-1:0],
                                                request.virt_address, 2'd0),
                                     '0, ST_OK, '0, 1'b1);
          end
        end
        KIND_READ_RESP: begin
          if (active && !awaiting) begin
            old_entry_next = rdata;
            if (level == LEAF_LEVEL) begin
              if (operation == OP_MAP) begin
                batch.count   = 2'd3;
                batch.item[0] = make_res(RES_WRITE, entry_addr(table_frame, saved_virt, level),
                                         compose(rdata, 1'b1, saved_flags[FLAG_W], user,
                                                 saved_flags[FLAG_NX], saved_phys_frame),
                                         ST_OK, '0, 1'b0);
                batch.item[1] = make_res(RES_INVAL, 52'(saved_virt), '0, ST_OK, '0, 1'b0);
                batch.item[2] = make_res(RES_DONE, '0, '0, ST_OK, '0, 1'b1);
                active_next   = 1'b0;
              end else if (!rdata[0]) begin
                batch.count   = 2'd1;
                batch.item[0] = make_res(RES_DONE, '0, '0, ST_NOT_PRESENT, '0, 1'b1);
                active_next   = 1'b0;
              end else if (operation == OP_TRANSLATE) begin
                batch.count   = 2'd1;
                batch.item[0] = make_res(RES_DONE, '0, '0, ST_OK,
                                         {40'(ent_frame), saved_virt[11:0] & OFS_MASK}, 1'b1);
                active_next   = 1'b0;
              end else begin
                batch.count   = 2'd3;
                batch.item[0] = make_res(RES_WRITE, entry_addr(table_frame, saved_virt, level),
                                         rdata & ~ENT_P, ST_OK, '0, 1'b0);
                batch.item[1] = make_res(RES_INVAL, 52'(saved_virt), '0, ST_OK, '0, 1'b0);
                batch.item[2] = make_res(RES_DONE, '0, '0, ST_OK, '0, 1'b1);
                active_next   = 1'b0;
              end
            end else if (!rdata[0]) begin
              batch.count = 2'd1;
              if (operation == OP_MAP) begin
                awaiting_next = 1'b1;
                batch.item[0] = make_res(RES_REQ_PAGE, '0, '0, ST_OK, '0, 1'b1);
              end else begin
                batch.item[0] = make_res(RES_DONE, '0, '0, ST_NOT_PRESENT, '0, 1'b1);
                active_next   = 1'b0;
              end
            end else begin
              table_frame_next = ent_frame;
              level_next       = level_inc;
              if (operation == OP_MAP) begin
                batch.count   = 2'd2;
                batch.item[0] = make_res(RES_WRITE, entry_addr(table_frame, saved_virt, level),
                                         rdata | ENT_W | (user ? ENT_U : 64'd0),
                                         ST_OK, '0, 1'b0);
                batch.item[1] = make_res(RES_READ, entry_addr(ent_frame, saved_virt, level_inc),
                                         '0, ST_OK, '0, 1'b1);
              end else begin
                batch.count   = 2'd1;
                batch.item[0] = make_res(RES_READ, entry_addr(ent_frame, saved_virt, level_inc),
                                         '0, ST_OK, '0, 1'b1);
              end
            end
          end
        end
        KIND_ALLOC_RESP: begin
          if (active && awaiting) begin
            awaiting_next = 1'b0;
            if (new_alloc == '0) begin
              batch.count   = 2'd1;
              batch.item[0] = make_res(RES_DONE, '0, '0, ST_NO_MEM, '0, 1'b1);
              active_next   = 1'b0;
            end else begin
              batch.count      = 2'd3;
              batch.item[0]    = make_res(RES_CLEAR, {40'(new_alloc), 12'd0}, '0, ST_OK, '0,
                                          1'b0);
              batch.item[1]    = make_res(RES_WRITE, entry_addr(table_frame, saved_virt, level),
                                          compose(old_entry, 1'b1, 1'b1, user, 1'b0,
                                                  new_alloc),
                                          ST_OK, '0, 1'b0);
              batch.item[2]    = make_res(RES_READ, entry_addr(new_alloc, saved_virt, level_inc),
                                          '0, ST_OK, '0, 1'b1);
              table_frame_next = new_alloc;
              level_next       = level_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      awaiting  <= 1'b0;
      operation <= OP_TRANSLATE;
      level     <= 2'd0;
    end else begin
      active    <= active_next;
      awaiting  <= awaiting_next;
      operation <= operation_next;
      level     <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    table_frame      <= table_frame_next;
    saved_virt       <= saved_virt_next;
    saved_phys_frame <= saved_phys_frame_next;
    saved_flags      <= saved_flags_next;
    old_entry        <= old_entry_next;
  end

endmodule

`default_nettype wire

[hw/rtl/ptw_outq.sv]
`default_nettype none

module ptw_outq import ptw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  batch_t batch,
  output logic   strobe,
  output res_t   result,
  output logic   busy
);

  res_t [MAX_RES-1:0] slot;
  logic [1:0]         cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= batch.count;
    end else if (cnt != 2'd0) begin
      cnt <= cnt - 2'd1;
    end
  end

  // results shift toward slot 0, which drives the ports
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= batch.item;
    end else begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign strobe = (cnt != 2'd0);
  assign result = slot[0];
  assign busy   = (cnt > 2'd1);

endmodule

`default_nettype wire

[hw/rtl/four_level_page_table_engine.sv]
`default_nettype none

// Four-level page table walker. Requests (translate, map, unmap) and the
// memory read and page allocation responses all enter on the same port, one
// item at the clock edge where start is high and busy is low. An item's
// results (at most three: entry reads and writes, page request, page clear,
// TLB invalidate, done) appear from the next cycle on, one per cycle, each
// for a single cycle with strobe high; the receiver cannot stall them, and
// last marks the final result of the item. busy is high while more than one
// result is still to be shown, so a new item is taken in the cycle that
// shows the last result. An item therefore keeps the port busy until its
// last result is shown, which the three-entry result buffer holds; a whole
// walk takes as long as the external memory and allocator need to answer.

module four_level_page_table_engine import ptw_pkg::*; #(
  parameter int FRAME_BITS = DEF_FRAME_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  logic   accept;
  batch_t batch;

  assign accept = start && !busy;

  ptw_walk #(
    .FRAME_BITS(FRAME_BITS)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .request(request),
    .batch  (batch)
  );

  ptw_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .batch (batch),
    .strobe(strobe),
    .result(result),
    .busy  (busy)
  );

endmodule

`default_nettype wire

[hw/rtl/ptw_checker.sv]
`default_nettype none

module ptw_checker import ptw_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic strobe,
  input wire res_t result
);

  // reset leaves nothing pending
  assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("results pending after reset");

  // busy only while a result is on the ports
  assert property (@(posedge clk) disable iff (rst) busy |-> strobe)
    else $error("busy without a result");

  // results of one request come in consecutive cycles
  assert property (@(posedge clk) disable iff (rst) strobe && !result.last |=> strobe)
    else $error("gap inside a result group");

  // a new request can follow the last result
  assert property (@(posedge clk) disable iff (rst) strobe && result.last |-> !busy)
    else $error("busy on the last result");

  // status only on done
  assert property (@(posedge clk) disable iff (rst)
                   strobe && result.res_kind != RES_DONE |-> result.status == ST_OK)
    else $error("status outside done");

endmodule

bind four_level_page_table_engine ptw_checker u_ptw_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .strobe(strobe),
  .result(result)
);

`default_nettype wire

[sim/four_level_page_table_engine_test.sv]
module four_level_page_table_engine_test import ptw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FRAME_FIELD = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic strobe;
  res_t result;

  // walker state as predicted
  bit walk_busy;
  logic [1:0] walk_op;
  logic [1:0] walk_level;
  bit wait_page;
  logic [39:0] tbl_frame;
  logic [39:0] leaf_frame;
  logic [47:0] walk_va;
  logic [2:0] walk_flags;
  logic [63:0] last_entry;

  res_t pending_results[$];
  int results_made;
  int n_effective;
  int err_count;
  int idle_pct;
  int present_pct = 80;

  // memory image seen by the walker
  logic [63:0] mem_img [logic [51:0]];
  bit zero_page [logic [39:0]];
  logic [63:0] read_script[$];
  logic [39:0] alloc_script[$];
  logic [39:0] pool_root[$];
  logic [47:0] pool_va[$];

  four_level_page_table_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic logic [51:0] entry_address();
    logic [47:0] shifted;
    shifted = walk_va >> (39 - 9 * int'(walk_level));
    return {tbl_frame, shifted[8:0], 3'b000};
  endfunction

  function automatic logic [63:0] build_entry(input logic [63:0] old, input bit p, input bit w,
                                              input bit u, input bit nx,
                                              input logic [39:0] frame);
    logic [63:0] e;
    e = old & ~(ENT_P | ENT_W | ENT_U | ENT_NX | FRAME_FIELD);
    if (p) e = e | ENT_P;
    if (w) e = e | ENT_W;
    if (u) e = e | ENT_U;
    if (nx) e = e | ENT_NX;
    e[51:12] = frame;
    return e;
  endfunction

  function automatic void emit(input logic [2:0] k, input logic [51:0] a, input logic [63:0] d,
                               input logic [1:0] st, input logic [51:0] pa, input bit lst);
    res_t r;
    r.res_kind = k;
    r.mem_address = a;
    r.write_data = d;
    r.status = st;
    r.phys_result = pa;
    r.last = lst;
    pending_results.push_back(r);
    results_made++;
    if (k == RES_WRITE) mem_img[a] = d;
    if (k == RES_CLEAR) begin
      zero_page[a[51:12]] = 1'b1;
      for (int i = 0; i < 512; i++) begin
        if (mem_img.exists({a[51:12], 9'(i), 3'b000})) mem_img.delete({a[51:12], 9'(i), 3'b000});
      end
    end
  endfunction

  function automatic void walk_step(input req_t r);
    logic [63:0] e;
    bit user;
    user = walk_flags[FLAG_U];
    if (r.kind <= KIND_UNMAP) begin
      if (walk_busy) return;
      walk_busy = 1'b1;
      walk_op = r.kind[1:0];
      walk_level = '0;
      wait_page = 1'b0;
      tbl_frame = r.root_frame;
      walk_va = r.virt_address;
      leaf_frame = r.phys_frame;
      walk_flags = {r.set_no_exec, r.set_user, r.set_writable};
      last_entry = '0;
      emit(RES_READ, entry_address(), '0, ST_OK, '0, 1'b1);
    end else if (r.kind == KIND_READ_RESP) begin
      if (!walk_busy || wait_page) return;
      e = r.read_data;
      last_entry = e;
      if (walk_level == LEAF_LEVEL) begin
        walk_busy = 1'b0;
        if (walk_op == OP_MAP) begin
          emit(RES_WRITE, entry_address(), build_entry(e, 1'b1, walk_flags[FLAG_W], user,
               walk_flags[FLAG_NX], leaf_frame), ST_OK, '0, 1'b0);
          emit(RES_INVAL, {4'b0, walk_va}, '0, ST_OK, '0, 1'b0);
          emit(RES_DONE, '0, '0, ST_OK, '0, 1'b1);
        end else if ((e & ENT_P) == '0) begin
          emit(RES_DONE, '0, '0, ST_NOT_PRESENT, '0, 1'b1);
        end else if (walk_op == OP_TRANSLATE) begin
          emit(RES_DONE, '0, '0, ST_OK, {e[51:12], walk_va[11:0]}, 1'b1);
        end else begin
          emit(RES_WRITE, entry_address(), e & ~ENT_P, ST_OK, '0, 1'b0);
          emit(RES_INVAL, {4'b0, walk_va}, '0, ST_OK, '0, 1'b0);
          emit(RES_DONE, '0, '0, ST_OK, '0, 1'b1);
        end
      end else if ((e & ENT_P) == '0) begin
        if (walk_op == OP_MAP) begin
          wait_page = 1'b1;
          emit(RES_REQ_PAGE, '0, '0, ST_OK, '0, 1'b1);
        end else begin
          walk_busy = 1'b0;
          emit(RES_DONE, '0, '0, ST_NOT_PRESENT, '0, 1'b1);
        end
      end else begin
        if (walk_op == OP_MAP)
          emit(RES_WRITE, entry_address(), e | ENT_W | (user ? ENT_U : '0), ST_OK, '0, 1'b0);
        tbl_frame = e[51:12];
        walk_level = walk_level + 2'd1;
        emit(RES_READ, entry_address(), '0, ST_OK, '0, 1'b1);
      end
    end else if (r.kind == KIND_ALLOC_RESP) begin
      if (!walk_busy || !wait_page) return;
      wait_page = 1'b0;
      if (r.alloc_frame == '0) begin
        walk_busy = 1'b0;
        emit(RES_DONE, '0, '0, ST_NO_MEM, '0, 1'b1);
      end else begin
        emit(RES_CLEAR, {r.alloc_frame, 12'h000}, '0, ST_OK, '0, 1'b0);
        emit(RES_WRITE, entry_address(), build_entry(last_entry, 1'b1, 1'b1, user, 1'b0,
             r.alloc_frame), ST_OK, '0, 1'b0);
        tbl_frame = r.alloc_frame;
        walk_level = walk_level + 2'd1;
        emit(RES_READ, entry_address(), '0, ST_OK, '0, 1'b1);
      end
    end
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.kind = 3'($urandom_range(7));
    r.root_frame = 40'({$urandom, $urandom});
    r.virt_address = 48'({$urandom, $urandom});
    r.phys_frame = 40'({$urandom, $urandom});
    r.set_writable = 1'($urandom_range(1));
    r.set_user = 1'($urandom_range(1));
    r.set_no_exec = 1'($urandom_range(1));
    r.read_data = {$urandom, $urandom};
    r.alloc_frame = 40'({$urandom, $urandom});
    return r;
  endfunction

  function automatic req_t random_walk_req();
    req_t r;
    int pick;
    int i;
    r = random_fields();
    pick = $urandom_range(99);
    r.kind = (pick < 40) ? KIND_TRANSLATE : (pick < 75) ? KIND_MAP : KIND_UNMAP;
    if (pool_va.size() != 0 && $urandom_range(1) == 1) begin
      i = $urandom_range(pool_va.size() - 1);
      r.root_frame = pool_root[i];
      r.virt_address = pool_va[i];
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge that took the request, or after an optional idle pause
  task automatic send_req(input req_t r);
    int made;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    made = results_made;
    walk_step(r);
    if (results_made != made) n_effective++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // plays memory and allocator until the walk ends
  task automatic run_walk(input req_t q, input bit noisy, input bit drain);
    req_t r;
    logic [63:0] word;
    logic [51:0] a;
    send_req(q);
    while (walk_busy) begin
      if (noisy && $urandom_range(99) < 10) begin
        r = random_fields();
        case ($urandom_range(2))
          0: r.kind = 3'($urandom_range(5, 7));
          1: r.kind = 3'($urandom_range(KIND_TRANSLATE, KIND_UNMAP));
          default: r.kind = wait_page ? KIND_READ_RESP : KIND_ALLOC_RESP;
        endcase
        send_req(r);
      end
      if (drain) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      r = random_fields();
      if (wait_page) begin
        r.kind = KIND_ALLOC_RESP;
        if (alloc_script.size() != 0) r.alloc_frame = alloc_script.pop_front();
        else if ($urandom_range(99) < 8) r.alloc_frame = '0;
        else if (r.alloc_frame == '0) r.alloc_frame = 40'd1;
      end else begin
        r.kind = KIND_READ_RESP;
        a = entry_address();
        if (read_script.size() != 0) begin
          word = read_script.pop_front();
          mem_img[a] = word;
        end else if (mem_img.exists(a)) begin
          word = mem_img[a];
        end else if (zero_page.exists(a[51:12])) begin
          word = '0;
        end else begin
          word = {$urandom, $urandom};
          word[0] = ($urandom_range(99) < present_pct);
          mem_img[a] = word;
        end
        r.read_data = word;
      end
      send_req(r);
    end
  endtask

  task automatic test_translate_walks();
    req_t r;
    r = random_fields();
    r.kind = KIND_TRANSLATE;
    r.root_frame = '1;
    r.virt_address = '1;
    read_script = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};
    run_walk(r, 1'b0, 1'b0);
    // top level missing
    r = random_fields();
    r.kind = KIND_TRANSLATE;
    r.root_frame = '0;
    r.virt_address = '0;
    read_script = '{64'h0};
    run_walk(r, 1'b0, 1'b0);
  endtask

  task automatic test_map_walks();
    req_t r;
    // missing levels get pages, present levels get writable and user
    r = random_fields();
    r.kind = KIND_MAP;
    r.phys_frame = '1;
    r.set_writable = 1'b1;
    r.set_user = 1'b1;
    r.set_no_exec = 1'b1;
    read_script = '{64'h0, 64'h0000_0123_4567_8001, 64'h7FF0_0000_0000_0FF8,
                    64'h7FF0_0000_0000_0FF8};
    alloc_script = '{40'hFF_FFFF_FFFF, 40'h00_0000_0001};
    run_walk(r, 1'b0, 1'b0);
    r = random_fields();
    r.kind = KIND_MAP;
    r.phys_frame = '0;
    r.set_writable = 1'b0;
    r.set_user = 1'b0;
    r.set_no_exec = 1'b0;
    read_script = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};
    run_walk(r, 1'b0, 1'b0);
    // out of memory, with a wrong response and a request while busy
    r = random_fields();
    r.kind = KIND_MAP;
    send_req(r);
    r = random_fields();
    r.kind = KIND_READ_RESP;
    r.read_data = 64'hFFFF_FFFF_FFFF_FFFE;
    send_req(r);
    r = random_fields();
    r.kind = KIND_READ_RESP;
    send_req(r);
    r = random_fields();
    r.kind = KIND_TRANSLATE;
    send_req(r);
    r = random_fields();
    r.kind = KIND_ALLOC_RESP;
    r.alloc_frame = '0;
    send_req(r);
  endtask

  task automatic test_unmap_walks();
    req_t r;
    r = random_fields();
    r.kind = KIND_UNMAP;
    read_script = '{64'h0000_0AAA_AAAA_A001, 64'h0005_5555_5555_5001, 64'h0000_0000_0000_1001,
                    ALL_ONES};
    run_walk(r, 1'b0, 1'b0);
    r = random_fields();
    r.kind = KIND_UNMAP;
    read_script = '{64'h0000_0000_0000_2001, 64'h0};
    run_walk(r, 1'b0, 1'b0);
  endtask

  task automatic test_ignored_items();
    req_t r;
    r = random_fields();
    r.kind = KIND_READ_RESP;
    send_req(r);
    r = random_fields();
    r.kind = KIND_ALLOC_RESP;
    send_req(r);
    for (int k = 5; k < 8; k++) begin
      r = random_fields();
      r.kind = 3'(k);
      send_req(r);
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 0;
    run_walk(random_walk_req(), 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle, input int target);
    req_t r;
    int base;
    idle_pct = idle;
    base = n_effective;
    while (n_effective - base < target) begin
      // stray response or unused kind while idle
      if ($urandom_range(99) < 5) begin
        r = random_fields();
        r.kind = 3'($urandom_range(KIND_READ_RESP, 7));
        send_req(r);
      end
      r = random_walk_req();
      run_walk(r, 1'b1, 1'b0);
      if (r.kind == KIND_MAP) begin
        pool_root.push_back(r.root_frame);
        pool_va.push_back(r.virt_address);
        if (pool_va.size() > 16) begin
          void'(pool_root.pop_front());
          void'(pool_va.pop_front());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (strobe === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", result.res_kind));
        end else begin
          want = pending_results.pop_front();
          compare_field("res_kind", result.res_kind, want.res_kind);
          compare_field("mem_address", result.mem_address, want.mem_address);
          compare_field("write_data", result.write_data, want.write_data);
          compare_field("status", result.status, want.status);
          compare_field("phys_result", result.phys_result, want.phys_result);
          compare_field("last", result.last, want.last);
        end
      end else if (strobe !== 1'b0) begin
        report_mismatch("strobe unknown");
      end
    end
  end

  initial begin
    #200_000;
    $display("[four_level_page_table_engine] ERROR");
    $finish;
  end

  initial begin
    idle_pct = 20;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_translate_walks();
    test_map_walks();
    test_unmap_walks();
    test_ignored_items();
    test_drain_pause();
    test_random_traffic(20, 40);
    test_random_traffic(68, 40);
    test_random_traffic(0, 40);
    start <= 1'b0;
    for (int i = 0; i < 200 && pending_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_results.size()));
    if (err_count == 0) begin
      $display("[four_level_page_table_engine] OK");
    end else begin
      $display("[four_level_page_table_engine] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_walk.sv
hw/rtl/ptw_outq.sv
hw/rtl/four_level_page_table_engine.sv
hw/rtl/ptw_checker.sv
sim/four_level_page_table_engine_test.sv
